>>> hw/rtl/clr_pkg.sv
// Package for the command line receiver: character codes, event codes,
// controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

    // Default line store length
    localparam int LINE_LENGTH_DEF = 64;

    // APB address width and register indexes (word addressed)
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_CAPTURE = '0;

    // Character codes
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_CTRL_X = 8'd24;
    localparam logic [7:0] CH_CTRL_Y = 8'd25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_DEL    = 8'd127;

    // Event codes on the result channel
    typedef logic [3:0] t_event;
    localparam t_event EV_CAPTURED   = 4'd0;
    localparam t_event EV_ABORT      = 4'd1;
    localparam t_event EV_UNLOCK     = 4'd2;
    localparam t_event EV_STOP_JOG   = 4'd3;
    localparam t_event EV_STOP_REQ   = 4'd4;
    localparam t_event EV_STATUS     = 4'd5;
    localparam t_event EV_LONG       = 4'd6;
    localparam t_event EV_LINE_BYTE  = 4'd7;
    localparam t_event EV_EMPTY      = 4'd8;
    localparam t_event EV_QUERY_BYTE = 4'd9;
    localparam t_event EV_OK         = 4'd10;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SINGLE,
        S_UNLOCK,
        S_OK,
        S_READ,
        S_EMIT
    } t_state;

    // What the current byte asks for
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SINGLE,
        ACT_UNLOCK_OK,
        ACT_LINE
    } t_act;

    // Which result the output register loads
    typedef enum logic [1:0] {
        PUSH_SINGLE,
        PUSH_UNLOCK,
        PUSH_OK,
        PUSH_LINE
    } t_push_sel;

    typedef struct packed {
        logic      in_ready;
        logic      apply;
        logic      rd;
        logic      push;
        t_push_sel sel;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        t_act act;
        logic halted;
        logic out_free;
        logic last_byte;
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/clr_in_if.sv
// Input channel: one received byte plus machine status flags per request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface clr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       system_halted;
    logic       continuous_jog;
    logic       query_queue_full;

    modport source (
        output valid, rx_byte, system_halted, continuous_jog, query_queue_full,
        input  ready
    );
    modport sink (
        input  valid, rx_byte, system_halted, continuous_jog, query_queue_full,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/clr_out_if.sv
// Result channel: event code, data byte and last-of-item marker per request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface clr_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] data_byte;
    logic       last;

    modport source (
        output valid, event_res, data_byte, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, data_byte, last,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/clr_ctrl.sv
// Controller state machine for the command line receiver.
// Depends on clr_pkg; talks to clr_datapath through t_cmd / t_status.
`timescale 1ns / 1ps
`default_nettype none

module clr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  clr_pkg::t_status i_status,
    output clr_pkg::t_cmd    o_cmd
);
    import clr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                case (i_status.act)
                    ACT_NONE:      n_state = S_IDLE;
                    ACT_SINGLE:    n_state = S_SINGLE;
                    ACT_UNLOCK_OK: n_state = i_status.halted ? S_UNLOCK : S_OK;
                    ACT_LINE:      n_state = S_READ;
                    default:       n_state = S_IDLE;
                endcase
            end
            S_SINGLE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_UNLOCK: begin
                if (i_status.out_free) n_state = S_OK;
            end
            S_OK: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = i_status.last_byte ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = PUSH_SINGLE;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.apply = 1'b1;
            end
            S_SINGLE: begin
                o_cmd.push = i_status.out_free;
                o_cmd.sel  = PUSH_SINGLE;
            end
            S_UNLOCK: begin
                o_cmd.push = i_status.out_free;
                o_cmd.sel  = PUSH_UNLOCK;
            end
            S_OK: begin
                o_cmd.push = i_status.out_free;
                o_cmd.sel  = PUSH_OK;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_EMIT: begin
                o_cmd.push = i_status.out_free;
                o_cmd.sel  = PUSH_LINE;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/clr_datapath.sv
// Datapath: input latch, byte classification, line store memory,
// line count / discard state and the output register.
// Depends on clr_pkg, clr_in_if, clr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module clr_datapath #(
    parameter int LINE_LENGTH = clr_pkg::LINE_LENGTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_capture_mode,
    input  clr_pkg::t_cmd    i_cmd,
    output clr_pkg::t_status o_status,
    clr_in_if.sink           i_in,
    clr_out_if.source        o_out
);
    import clr_pkg::*;

    localparam int CNT_W = $clog2(LINE_LENGTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_LENGTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    // Latched request
    logic [7:0] r_byte;
    logic       r_halted;
    logic       r_jog;
    logic       r_qfull;

    // Line state
    logic [CNT_W-1:0] r_count;
    logic             r_discard;
    logic [7:0]       r_first;
    logic [7:0]       r_second;
    logic [7:0]       r_store [LINE_LENGTH];

    // Emission state
    t_event           r_ev;
    logic [7:0]       r_data;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_addr;
    logic [7:0]       r_rdata;

    // Output register
    logic   r_out_valid;
    t_event r_out_ev;
    logic [7:0] r_out_data;
    logic   r_out_last;

    // Classification results
    t_act             act;
    t_event           n_ev;
    logic [7:0]       n_data;
    logic [CNT_W-1:0] n_count;
    logic             n_discard;
    logic             store_we;
    logic             is_cmd_line;
    logic             out_free;
    logic             last_byte;

    assign i_in.ready = i_cmd.in_ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_byte  = (r_addr == (r_len - CNT_ONE));

    assign is_cmd_line = (r_count >= CNT_TWO) && (r_first == CH_DOLLAR) &&
                         ((r_second == CH_I) || (r_second == CH_S) || (r_second == CH_X));

    // Classify the latched byte against the current line state
    always_comb begin
        act       = ACT_NONE;
        n_ev      = EV_CAPTURED;
        n_data    = 8'd0;
        n_count   = r_count;
        n_discard = r_discard;
        store_we  = 1'b0;
        if (i_capture_mode) begin
            act    = ACT_SINGLE;
            n_ev   = EV_CAPTURED;
            n_data = r_byte;
        end else if (r_byte == CH_CTRL_X) begin
            if (!r_halted) begin
                act  = ACT_SINGLE;
                n_ev = EV_ABORT;
            end
            n_discard = 1'b0;
            n_count   = '0;
        end else if (r_byte == CH_CTRL_Y) begin
            act = ACT_SINGLE;
            if (r_halted)   n_ev = EV_UNLOCK;
            else if (r_jog) n_ev = EV_STOP_JOG;
            else            n_ev = EV_STOP_REQ;
        end else if (r_byte == CH_QUERY) begin
            if (!r_qfull) begin
                act  = ACT_SINGLE;
                n_ev = EV_STATUS;
            end
        end else if (r_discard) begin
            if (r_byte == CH_LF) n_discard = 1'b0;
        end else if (r_count >= CNT_FULL) begin
            act       = ACT_SINGLE;
            n_ev      = EV_LONG;
            n_discard = 1'b1;
            n_count   = '0;
        end else if (r_byte == CH_LF) begin
            if (is_cmd_line) begin
                if (r_second == CH_X) begin
                    act = ACT_UNLOCK_OK;
                end else if (!r_qfull) begin
                    act  = ACT_LINE;
                    n_ev = EV_QUERY_BYTE;
                end
            end else if (r_count == '0) begin
                act  = ACT_SINGLE;
                n_ev = EV_EMPTY;
            end else begin
                act  = ACT_LINE;
                n_ev = EV_LINE_BYTE;
            end
            n_count = '0;
        end else if (r_byte == CH_CR) begin
            act = ACT_NONE;
        end else if ((r_byte == CH_BS) || (r_byte == CH_DEL)) begin
            if (r_count != '0) n_count = r_count - CNT_ONE;
        end else begin
            store_we = 1'b1;
            n_count  = r_count + CNT_ONE;
        end
    end

    assign o_status.in_valid  = i_in.valid;
    assign o_status.act       = act;
    assign o_status.halted    = r_halted;
    assign o_status.out_free  = out_free;
    assign o_status.last_byte = last_byte;

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte   <= i_in.rx_byte;
            r_halted <= i_in.system_halted;
            r_jog    <= i_in.continuous_jog;
            r_qfull  <= i_in.query_queue_full;
        end
    end

    // Line count and discard mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_discard <= 1'b0;
        end else if (i_cmd.apply) begin
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

    // Line store write, with copies of the first two characters
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && store_we) begin
            r_store[r_count] <= r_byte;
            if (r_count == '0)    r_first  <= r_byte;
            if (r_count == CNT_ONE) r_second <= r_byte;
        end
    end

    // Line store read, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_store[r_addr];
        end
    end

    // Event and walk setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_ev   <= n_ev;
            r_data <= n_data;
            r_len  <= r_count;
            r_addr <= '0;
        end else if (i_cmd.push && (i_cmd.sel == PUSH_LINE)) begin
            r_addr <= r_addr + CNT_ONE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            case (i_cmd.sel)
                PUSH_SINGLE: begin
                    r_out_ev   <= r_ev;
                    r_out_data <= r_data;
                    r_out_last <= 1'b1;
                end
                PUSH_UNLOCK: begin
                    r_out_ev   <= EV_UNLOCK;
                    r_out_data <= 8'd0;
                    r_out_last <= 1'b0;
                end
                PUSH_OK: begin
                    r_out_ev   <= EV_OK;
                    r_out_data <= 8'd0;
                    r_out_last <= 1'b1;
                end
                PUSH_LINE: begin
                    r_out_ev   <= r_ev;
                    r_out_data <= r_rdata;
                    r_out_last <= last_byte;
                end
                default: begin
                    r_out_ev   <= r_ev;
                    r_out_data <= 8'd0;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_ev;
    assign o_out.data_byte = r_out_data;
    assign o_out.last      = r_out_last;

endmodule

`default_nettype wire

>>> hw/rtl/command_line_receiver.sv
// Top level of the command line receiver: APB register, controller and datapath.
// Depends on clr_pkg, clr_in_if, clr_out_if, clr_ctrl, clr_datapath.
//
//   Channel   Dir   Payload                                             Handshake
//   i_in      in    rx_byte, system_halted, continuous_jog,             valid/ready
//                   query_queue_full
//   o_out     out   event_res, data_byte, last                          valid/ready
//   APB       in    capture_mode at byte address 0                      psel/penable
//
// A byte that gives one result is accepted, classified and then loaded into the output
// register; unlock is loaded before ok. Each byte of a line is one registered line
// store read followed by one output load.
// One request is worked on at a time; ready is high only while idle.
// Reset is synchronous, active low; the line store needs no clearing pass.
// A stalled output holds the result register and the line walk waits.
`timescale 1ns / 1ps
`default_nettype none

module command_line_receiver #(
    parameter int LINE_LENGTH = clr_pkg::LINE_LENGTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    clr_in_if.sink                           i_in,
    clr_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [clr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [clr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import clr_pkg::*;

    logic    r_capture_mode;
    logic    sel_capture;
    t_cmd    cmd;
    t_status status;

    // Register decode
    assign pready      = 1'b1;
    assign sel_capture = (paddr[APB_ADDR_W-1:2] == REG_CAPTURE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && sel_capture) begin
            r_capture_mode <= pwdata[0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (sel_capture) prdata[0] = r_capture_mode;
    end

    clr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    clr_datapath #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_capture_mode (r_capture_mode),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_in           (i_in),
        .o_out          (o_out)
    );

endmodule

`default_nettype wire
